// ===== rtl/ilie_pkg.sv =====
// ----------------------------------------------------------------------------
// ilie_pkg
// Shared codes and default sizes for the indexed list block.
// ----------------------------------------------------------------------------
package ilie_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int ENTRY_BITS_DEF = 32;

  localparam int ACT_W = 3;
  localparam int ST_W  = 2;

  localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ERASE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== rtl/indexed_list_insert_erase_top.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_erase_top
// A new item is taken only after the result of the last one is loaded for output.
// Insert and erase shift the entries between the index and the end of the list;
// each moved entry costs one memory read and one write.
// ----------------------------------------------------------------------------
module indexed_list_insert_erase_top
  import ilie_pkg::*;
#(
  parameter  int DEPTH      = DEPTH_DEF,
  parameter  int ENTRY_BITS = ENTRY_BITS_DEF,
  localparam int IDX_W      = $clog2(DEPTH),
  localparam int CNT_W      = $clog2(DEPTH + 1),
  localparam int IN_W       = ((ACT_W + IDX_W + ENTRY_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((ENTRY_BITS + ST_W + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // action, index, entry_value
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // read_value, status, entry_count
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1;
  localparam logic [2:0] S_MV_RD  = 3'd2;
  localparam logic [2:0] S_MV_WR  = 3'd3;
  localparam logic [2:0] S_INS_LAST = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [2:0]            state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      ptr;
  logic [CNT_W-1:0]      stop;
  logic                  ins_mode;
  logic [IDX_W-1:0]      idx_q;
  logic [ENTRY_BITS-1:0] val_q;
  logic [ENTRY_BITS-1:0] res_value;
  logic [ST_W-1:0]       res_status;
  logic [ENTRY_BITS-1:0] out_value;
  logic [ST_W-1:0]       out_status;
  logic [CNT_W-1:0]      out_count;

  logic [ENTRY_BITS-1:0] mem [DEPTH];
  logic [ENTRY_BITS-1:0] rdata;
  logic                  mem_we;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_waddr;
  logic [IDX_W-1:0]      mem_raddr;
  logic [ENTRY_BITS-1:0] mem_wdata;

  logic [ACT_W-1:0]      in_action;
  logic [IDX_W-1:0]      in_index;
  logic [ENTRY_BITS-1:0] in_value;
  logic                  accept;
  logic                  in_range;
  logic                  full;
  logic [CNT_W-1:0]      ptr_adj;
  logic                  slot_free;

  assign in_action = s_tdata[ACT_W-1:0];
  assign in_index  = s_tdata[ACT_W +: IDX_W];
  assign in_value  = s_tdata[ACT_W + IDX_W +: ENTRY_BITS];

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign in_range  = CNT_W'(in_index) < count;
  assign full      = (count == CNT_FULL);
  assign slot_free = !m_tvalid || m_tready;

  // shared pointer step: down for insert, up for erase
  assign ptr_adj = ins_mode ? (ptr - CNT_ONE) : (ptr + CNT_ONE);

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = ptr[IDX_W-1:0];
    mem_raddr = ptr_adj[IDX_W-1:0];
    mem_wdata = rdata;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_READ: begin
              mem_re    = in_range;
              mem_raddr = in_index;
            end
            ACT_WRITE: begin
              mem_we    = in_range;
              mem_waddr = in_index;
              mem_wdata = in_value;
            end
            ACT_APPEND: begin
              mem_we    = !full;
              mem_waddr = count[IDX_W-1:0];
              mem_wdata = in_value;
            end
            default: ;
          endcase
        end
      end
      S_MV_RD: mem_re = 1'b1;
      S_MV_WR: mem_we = 1'b1;
      S_INS_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = val_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            idx_q     <= in_index;
            val_q     <= in_value;
            res_value <= '0;
            case (in_action)
              ACT_READ: begin
                if (in_range) begin
                  res_status <= ST_OK;
                  state      <= S_RDWAIT;
                end else begin
                  res_status <= ST_RANGE;
                  state      <= S_FIN;
                end
              end
              ACT_WRITE: begin
                res_status <= in_range ? ST_OK : ST_RANGE;
                state      <= S_FIN;
              end
              ACT_INSERT: begin
                if (!in_range) begin
                  res_status <= ST_RANGE;
                  state      <= S_FIN;
                end else if (full) begin
                  res_status <= ST_FULL;
                  state      <= S_FIN;
                end else begin
                  res_status <= ST_OK;
                  ins_mode   <= 1'b1;
                  ptr        <= count;
                  stop       <= CNT_W'(in_index);
                  state      <= S_MV_RD;
                end
              end
              ACT_ERASE: begin
                if (!in_range) begin
                  res_status <= ST_RANGE;
                  state      <= S_FIN;
                end else if (CNT_W'(in_index) == count - CNT_ONE) begin
                  res_status <= ST_OK;
                  count      <= count - CNT_ONE;
                  state      <= S_FIN;
                end else begin
                  res_status <= ST_OK;
                  ins_mode   <= 1'b0;
                  ptr        <= CNT_W'(in_index);
                  stop       <= count - CNT_ONE;
                  state      <= S_MV_RD;
                end
              end
              ACT_APPEND: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status <= ST_OK;
                  count      <= count + CNT_ONE;
                end
                state <= S_FIN;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          state <= S_FIN;
        end
        S_MV_RD: begin
          state <= S_MV_WR;
        end
        S_MV_WR: begin
          ptr <= ptr_adj;
          if (ptr_adj != stop) begin
            state <= S_MV_RD;
          end else if (ins_mode) begin
            state <= S_INS_LAST;
          end else begin
            count <= count - CNT_ONE;
            state <= S_FIN;
          end
        end
        S_INS_LAST: begin
          count <= count + CNT_ONE;
          state <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) begin
            out_value  <= res_value;
            out_status <= res_status;
            out_count  <= count;
            m_tvalid   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_RDWAIT) begin
        res_value <= rdata;
      end
    end
  end

  assign m_tdata = OUT_W'({out_count, out_status, out_value});

endmodule

// ===== rtl/ilie_checker.sv =====
// ----------------------------------------------------------------------------
// ilie_checker
// Port-level checks for the indexed list block, bound to the top level.
// ----------------------------------------------------------------------------
module ilie_checker
  import ilie_pkg::*;
#(
  parameter  int DEPTH      = DEPTH_DEF,
  parameter  int ENTRY_BITS = ENTRY_BITS_DEF,
  localparam int CNT_W      = $clog2(DEPTH + 1),
  localparam int OUT_W      = ((ENTRY_BITS + ST_W + CNT_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata   // read_value, status, entry_count
);

  logic [ENTRY_BITS-1:0] value;
  logic [ST_W-1:0]       status;
  logic [CNT_W-1:0]      count;

  assign value  = m_tdata[ENTRY_BITS-1:0];
  assign status = m_tdata[ENTRY_BITS +: ST_W];
  assign count  = m_tdata[ENTRY_BITS + ST_W +: CNT_W];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("took a beat while busy");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == ST_FULL |-> count == CNT_W'(DEPTH))
    else $error("store full with room left");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status != ST_OK |-> value == '0)
    else $error("data on a failed item");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> count <= CNT_W'(DEPTH))
    else $error("entry count past depth");

endmodule

bind indexed_list_insert_erase_top ilie_checker #(
  .DEPTH      (DEPTH),
  .ENTRY_BITS (ENTRY_BITS)
) u_ilie_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
